// File: rtl/core/etok_pkg.sv
// Shared types, constants and character-class helpers for the expression tokenizer.
package etok_pkg;

  localparam int MAX_LEN = 1024;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int START_W = 10;
  localparam int LEN_W   = 11;
  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 3;

  // Result queue: one item may push up to three results.
  localparam int MAX_RES = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_LITERAL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SYMBOL   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LPAREN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RPAREN   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COMMA    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_END      = 3'd6;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd7;

  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_SYMBOL  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic [CHAR_W-1:0]  first_char;
    logic               run_last;
  } tok_t;

  function automatic logic is_dig(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alp(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

// File: rtl/core/etok_if.sv
// Handshake channels for characters in and tokens out.
interface etok_char_if;
  import etok_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_text;
  modport source (output valid, char_code, end_of_text, input ready);
  modport sink (input valid, char_code, end_of_text, output ready);
endinterface

interface etok_token_if;
  import etok_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [START_W-1:0] token_start;
  logic [LEN_W-1:0]   token_length;
  logic [CHAR_W-1:0]  token_char;
  logic               run_last;
  modport source (output valid, token_kind, token_start, token_length, token_char, run_last,
                  input ready);
  modport sink (input valid, token_kind, token_start, token_length, token_char, run_last,
                output ready);
endinterface

// File: rtl/core/expression_tokenizer.sv
// Expression tokenizer: one character item in, zero to three token items out.
// Characters are taken one per cycle; each is classified and the scan state updated in
// the same cycle, and the tokens it causes are pushed into a four-entry result queue that
// drains one token per cycle while the output is ready. A character is accepted whenever
// the queue has room for three tokens, so characters flow at one per cycle as long as
// they produce about one token each on average; an item that yields two or three tokens
// (a pending token ended together with an operator and the end marker) holds the input
// while the queue drains. A character's tokens are registered in the queue on acceptance
// and leave it behind any already queued. Expressions close with an end marker, or with
// one error token on a second dot in a literal or on a character past the length limit.
module expression_tokenizer (
  input logic         clk,
  input logic         rst,
  etok_char_if.sink   chars,
  etok_token_if.source tokens
);
  import etok_pkg::*;

  mode_t              scan_mode, mode_next;
  logic               dot_seen, dot_next;
  logic [START_W-1:0] pending_start, pstart_next;
  logic [LEN_W-1:0]   pending_length, plen_next;
  logic [CHAR_W-1:0]  pending_first_char, pchar_next;
  logic [POS_W-1:0]   position, pos_next;
  logic               failed, failed_next;

  tok_t               res [MAX_RES];
  logic [1:0]         res_n;

  tok_t               queue [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  logic               accept, pop;

  assign chars.ready = (count <= Q_CNT_W'(Q_DEPTH - MAX_RES));
  assign accept      = chars.valid && chars.ready;
  assign pop         = tokens.valid && tokens.ready;

  // Scan one character: next state and the tokens it emits.
  always_comb begin
    logic [CHAR_W-1:0] c;
    logic              last;
    logic              taken;
    logic              err;
    logic              clear;
    logic              set_failed;
    tok_t              t;
    c           = chars.char_code;
    last        = chars.end_of_text;
    taken       = 1'b0;
    err         = 1'b0;
    clear       = 1'b0;
    set_failed  = 1'b0;
    mode_next   = scan_mode;
    dot_next    = dot_seen;
    pstart_next = pending_start;
    plen_next   = pending_length;
    pchar_next  = pending_first_char;
    pos_next    = position;
    failed_next = failed;
    res_n       = 2'd0;
    t           = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '0;
    end

    if (failed) begin
      // Drop characters up to the end of the expression.
      if (last) begin
        clear = 1'b1;
      end
    end else if (position >= POS_W'(MAX_LEN)) begin
      err = 1'b1;
    end else begin
      case (scan_mode)
        MODE_LITERAL: begin
          if (is_dig(c)) begin
            plen_next = pending_length + 1'b1;
            taken     = 1'b1;
          end else if (c == CH_DOT) begin
            if (dot_seen) begin
              err = 1'b1;
            end else begin
              dot_next  = 1'b1;
              plen_next = pending_length + 1'b1;
              taken     = 1'b1;
            end
          end else begin
            res[res_n] = '{KIND_LITERAL, pending_start, pending_length, pending_first_char,
                           1'b0};
            res_n      = res_n + 1'b1;
            mode_next  = MODE_IDLE;
          end
        end
        MODE_SYMBOL: begin
          if (is_dig(c) || is_alp(c) || c == CH_UNDER) begin
            plen_next = pending_length + 1'b1;
            taken     = 1'b1;
          end else begin
            res[res_n] = '{KIND_SYMBOL, pending_start, pending_length, pending_first_char,
                           1'b0};
            res_n      = res_n + 1'b1;
            mode_next  = MODE_IDLE;
          end
        end
        default: mode_next = MODE_IDLE;
      endcase

      if (!err) begin
        if (!taken) begin
          t = '{KIND_OPERATOR, position[START_W-1:0], LEN_W'(1), c, 1'b0};
          if (is_dig(c) || is_alp(c)) begin
            mode_next   = is_dig(c) ? MODE_LITERAL : MODE_SYMBOL;
            dot_next    = 1'b0;
            pstart_next = position[START_W-1:0];
            plen_next   = LEN_W'(1);
            pchar_next  = c;
          end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
            res[res_n] = t;
            res_n      = res_n + 1'b1;
          end else if (c == CH_LPAREN) begin
            t.kind     = KIND_LPAREN;
            res[res_n] = t;
            res_n      = res_n + 1'b1;
          end else if (c == CH_RPAREN) begin
            t.kind     = KIND_RPAREN;
            res[res_n] = t;
            res_n      = res_n + 1'b1;
          end else if (c == CH_COMMA) begin
            t.kind     = KIND_COMMA;
            res[res_n] = t;
            res_n      = res_n + 1'b1;
          end
        end

        pos_next = position + 1'b1;

        if (last) begin
          // Flush the pending token, then close with the end marker.
          if (mode_next == MODE_LITERAL) begin
            res[res_n] = '{KIND_LITERAL, pstart_next, plen_next, pchar_next, 1'b0};
            res_n      = res_n + 1'b1;
          end else if (mode_next == MODE_SYMBOL) begin
            res[res_n] = '{KIND_SYMBOL, pstart_next, plen_next, pchar_next, 1'b0};
            res_n      = res_n + 1'b1;
          end
          res[res_n] = '{KIND_END, '0, '0, '0, 1'b0};
          res_n      = res_n + 1'b1;
          clear      = 1'b1;
        end
      end
    end

    if (err) begin
      res[0]     = '{KIND_ERROR, position[START_W-1:0], '0, c, 1'b0};
      res_n      = 2'd1;
      clear      = 1'b1;
      set_failed = !last;
    end

    if (clear) begin
      mode_next   = MODE_IDLE;
      dot_next    = 1'b0;
      pstart_next = '0;
      plen_next   = '0;
      pchar_next  = '0;
      pos_next    = '0;
      failed_next = set_failed;
    end

    for (int k = 0; k < MAX_RES; k++) begin
      res[k].run_last = (2'(k) == res_n - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode          <= MODE_IDLE;
      dot_seen           <= 1'b0;
      pending_start      <= '0;
      pending_length     <= '0;
      pending_first_char <= '0;
      position           <= '0;
      failed             <= 1'b0;
    end else if (accept) begin
      scan_mode          <= mode_next;
      dot_seen           <= dot_next;
      pending_start      <= pstart_next;
      pending_length     <= plen_next;
      pending_first_char <= pchar_next;
      position           <= pos_next;
      failed             <= failed_next;
    end
  end

  // Result queue: push up to three tokens, pop one.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (2'(k) < res_n) begin
          queue[wr_ptr + Q_PTR_W'(k)] <= res[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(res_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (accept ? Q_CNT_W'(res_n) : '0) - (pop ? Q_CNT_W'(1) : '0);
    end
  end

  assign tokens.valid        = (count != '0);
  assign tokens.token_kind   = queue[rd_ptr].kind;
  assign tokens.token_start  = queue[rd_ptr].start;
  assign tokens.token_length = queue[rd_ptr].length;
  assign tokens.token_char   = queue[rd_ptr].first_char;
  assign tokens.run_last     = queue[rd_ptr].run_last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    position <= POS_W'(MAX_LEN))
    else $error("position beyond length limit");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && chars.end_of_text |=> scan_mode == MODE_IDLE && position == '0 && !failed)
    else $error("scan state not cleared after last character");

  a_failed_silent: assert property (@(posedge clk) disable iff (rst)
    accept && failed |-> res_n == 2'd0)
    else $error("token emitted while dropping characters");

endmodule
